// ===== hw/rtl/mi3_pkg.sv =====
`timescale 1ns / 1ps

package mi3_pkg;

  // Field widths
  localparam int ELEM_W    = 16;
  localparam int COF_W     = 33;
  localparam int DET_W     = 49;
  localparam int INV_W     = 32;
  localparam int N_ENT     = 9;
  localparam int ROW_W     = 3;

  // Queue between front and back
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Divider: one quotient bit per stage
  localparam int DIV_STEPS = INV_W;
  localparam int NUM_W     = 61;
  localparam int DEN_W     = DET_W + 1;
  localparam int WIDE_W    = DEN_W + DIV_STEPS;
  localparam int BACK_LAT  = DIV_STEPS + 3;

  // Selector codes
  localparam logic FUNC_GENERAL   = 1'b0;
  localparam logic FUNC_SYMMETRIC = 1'b1;

  localparam logic [INV_W-1:0] INV_MAX = {1'b0, {(INV_W-1){1'b1}}};
  localparam logic [INV_W-1:0] INV_MIN = {1'b1, {(INV_W-1){1'b0}}};

  // Element index: a00=0 a01=1 a02=2 a10=3 a11=4 a12=5 a20=6 a21=7 a22=8
  // cofactor k = a[PA_L]*a[PA_R] - a[PB_L]*a[PB_R]
  localparam int unsigned PA_L [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned PA_R [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned PB_L [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned PB_R [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [2*ELEM_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic signed [DET_W-1:0] det_t;
  typedef logic signed [INV_W-1:0] inv_t;

  typedef struct packed {
    cof_t [N_ENT-1:0] cof;
    det_t             det;
    logic             sing;
    logic             sym;
  } mi3_job_t;

endpackage

// ===== hw/rtl/mi3_front.sv =====
`timescale 1ns / 1ps

module mi3_front import mi3_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_func,
  input  logic [N_ENT*ELEM_W-1:0] in_elems,
  input  logic [DET_W-1:0]        limit,
  output logic                    push,
  output mi3_job_t                push_data
);

  logic [5:0] v;

  elem_t a0 [N_ENT];
  logic  sym0, sym1, sym2, sym3, sym4;
  prod_t pa1 [N_ENT];
  prod_t pb1 [N_ENT];
  elem_t r1 [ROW_W];
  cof_t  cof2 [N_ENT];
  elem_t r2 [ROW_W];
  cof_t  cof3 [N_ENT];
  det_t  t3 [ROW_W];
  cof_t  cof4 [N_ENT];
  det_t  det4;
  logic [DET_W-1:0] mag;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[4:0], in_valid};
    end
  end

  // Capture elements
  always_ff @(posedge clk) begin
    for (int i = 0; i < N_ENT; i++) begin
      a0[i] <= elem_t'(in_elems[i*ELEM_W +: ELEM_W]);
    end
    sym0 <= (in_func == FUNC_SYMMETRIC);
  end

  // Form the two-element products and cofactors
  for (genvar k = 0; k < N_ENT; k++) begin : g_cof
    always_ff @(posedge clk) begin
      pa1[k]  <= prod_t'(a0[PA_L[k]]) * prod_t'(a0[PA_R[k]]);
      pb1[k]  <= prod_t'(a0[PB_L[k]]) * prod_t'(a0[PB_R[k]]);
      cof2[k] <= cof_t'(pa1[k]) - cof_t'(pb1[k]);
      cof3[k] <= cof2[k];
      cof4[k] <= cof3[k];
    end
  end

  // Carry row 0 and the selector
  always_ff @(posedge clk) begin
    for (int j = 0; j < ROW_W; j++) begin
      r1[j] <= a0[j];
      r2[j] <= r1[j];
    end
    sym1 <= sym0;
    sym2 <= sym1;
    sym3 <= sym2;
    sym4 <= sym3;
  end

  // Expand along row 0: cofactors of row 0 sit at 0, 3, 6
  always_ff @(posedge clk) begin
    t3[0] <= det_t'(r2[0]) * det_t'(cof2[0]);
    t3[1] <= det_t'(r2[1]) * det_t'(cof2[3]);
    t3[2] <= det_t'(r2[2]) * det_t'(cof2[6]);
    det4  <= t3[0] + t3[1] + t3[2];
  end

  assign mag = det4[DET_W-1] ? DET_W'(-det4) : DET_W'(det4);

  // Classify and hand to the queue
  always_ff @(posedge clk) begin
    for (int i = 0; i < N_ENT; i++) begin
      push_data.cof[i] <= cof4[i];
    end
    push_data.det  <= det4;
    push_data.sing <= (det4 == '0) || (mag < limit);
    push_data.sym  <= sym4;
  end

  assign push = v[5];

endmodule

// ===== hw/rtl/mi3_fifo.sv =====
`timescale 1ns / 1ps

module mi3_fifo import mi3_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  mi3_job_t push_data,
  input  logic     pop,
  output mi3_job_t pop_data,
  output logic     empty,
  output logic     full
);

  mi3_job_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  // Track pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assign pop_data = mem[rd_ptr];
  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(FIFO_DEPTH));

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== hw/rtl/mi3_div.sv =====
`timescale 1ns / 1ps

module mi3_div import mi3_pkg::*; (
  input  logic clk,
  input  logic en,
  input  cof_t cof,
  input  det_t det,
  output inv_t quo
);

  logic [COF_W-1:0] cmag;
  logic [DET_W-1:0] dmag;

  logic [NUM_W-1:0] num0;
  logic [DEN_W-1:0] den0;
  logic             neg0;

  logic [NUM_W-1:0] rem [DIV_STEPS+1];
  logic [DEN_W-1:0] den [DIV_STEPS+1];
  logic [INV_W-1:0] qv  [DIV_STEPS+1];
  logic             neg [DIV_STEPS+1];
  logic             ovf [DIV_STEPS+1];

  logic [INV_W-1:0] q;

  assign cmag = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
  assign dmag = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);

  // Form 2n+d over 2d for round to nearest
  always_ff @(posedge clk) begin
    if (en) begin
      num0 <= (NUM_W'(cmag) << 29) + NUM_W'(dmag);
      den0 <= {dmag, 1'b0};
      neg0 <= cof[COF_W-1] ^ det[DET_W-1];
    end
  end

  // Flag quotients of 2^32 and up
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num0;
      den[0] <= den0;
      qv[0]  <= '0;
      neg[0] <= neg0;
      ovf[0] <= (WIDE_W'(num0) >= {den0, {DIV_STEPS{1'b0}}});
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [WIDE_W-1:0] trial;
    logic              ge;

    assign trial = WIDE_W'(den[s]) << (DIV_STEPS - 1 - s);
    assign ge    = (WIDE_W'(rem[s]) >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? NUM_W'(WIDE_W'(rem[s]) - trial) : rem[s];
        den[s+1] <= den[s];
        qv[s+1]  <= {qv[s][INV_W-2:0], ge};
        neg[s+1] <= neg[s];
        ovf[s+1] <= ovf[s];
      end
    end
  end

  assign q = qv[DIV_STEPS];

  // Apply sign and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[DIV_STEPS]) begin
        if (ovf[DIV_STEPS] || (q[INV_W-1] && (q[INV_W-2:0] != '0))) begin
          quo <= inv_t'(INV_MIN);
        end else begin
          quo <= inv_t'(-q);
        end
      end else begin
        if (ovf[DIV_STEPS] || q[INV_W-1]) begin
          quo <= inv_t'(INV_MAX);
        end else begin
          quo <= inv_t'(q);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/mi3_back.sv =====
`timescale 1ns / 1ps

module mi3_back import mi3_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    empty,
  input  mi3_job_t                pop_data,
  output logic                    pop,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [N_ENT*INV_W-1:0]  out_inv,
  output det_t                    out_det,
  output logic                    out_sing
);

  logic en;
  logic vld  [BACK_LAT];
  det_t detp [BACK_LAT];
  logic sngp [BACK_LAT];
  logic symp [BACK_LAT];
  inv_t q    [N_ENT];

  assign en  = !vld[BACK_LAT-1] || out_ready;
  assign pop = en && !empty;

  // Advance valid bits with the whole back end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BACK_LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= pop;
      for (int i = 1; i < BACK_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // Carry determinant and flags beside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      detp[0] <= pop_data.det;
      sngp[0] <= pop_data.sing;
      symp[0] <= pop_data.sym;
      for (int i = 1; i < BACK_LAT; i++) begin
        detp[i] <= detp[i-1];
        sngp[i] <= sngp[i-1];
        symp[i] <= symp[i-1];
      end
    end
  end

  for (genvar k = 0; k < N_ENT; k++) begin : g_lane
    mi3_div u_div (
      .clk (clk),
      .en  (en),
      .cof (pop_data.cof[k]),
      .det (pop_data.det),
      .quo (q[k])
    );
  end

  // Zero singular results, mirror the upper triangle for the symmetric form
  always_comb begin
    for (int k = 0; k < N_ENT; k++) begin
      out_inv[k*INV_W +: INV_W] = q[k];
    end
    if (symp[BACK_LAT-1]) begin
      out_inv[3*INV_W +: INV_W] = q[1];
      out_inv[6*INV_W +: INV_W] = q[2];
      out_inv[7*INV_W +: INV_W] = q[5];
    end
    if (sngp[BACK_LAT-1]) begin
      out_inv = '0;
    end
  end

  assign out_valid = vld[BACK_LAT-1];
  assign out_det   = detp[BACK_LAT-1];
  assign out_sing  = sngp[BACK_LAT-1];

`ifndef SYNTHESIS
  a_pop_moves: assert property (@(posedge clk) disable iff (rst) pop |=> vld[0])
    else $error("popped job not in first divider stage");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid)
    else $error("result lost while stalled");
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |-> !pop)
    else $error("queue popped while back end stalled");
`endif

endmodule

// ===== hw/rtl/matrix3_inverse_cramer.sv =====
`timescale 1ns / 1ps

// 3x3 matrix inverse by adjugate and determinant.
// Input beat: s_axis_tdata carries a00..a22 (signed Q4.12), s_axis_tuser
// picks general (0) or symmetric (1) inverse; symmetric mirrors the upper
// triangle of the inverse into the lower one.
// Output beat: m_axis_tdata carries inv00..inv22 (signed Q16.16, saturated)
// and the exact determinant (scale 2^-36); m_axis_tuser is the singular flag,
// set when det is zero or |det| is below singular_limit, with the inverse then zeroed.
// cfg_we/cfg_wdata write singular_limit (reset value 1); write it only
// while the block is idle.
// Throughput: one matrix per cycle while s_axis_tready is high. The path
// from the accepting edge to the result runs through a 6-stage front (products,
// cofactors, determinant, classify), one queue slot and a 35-stage back end
// whose dividers resolve one quotient bit per stage.
// The front runs free and takes a beat while the 8-entry queue has a free
// credit; when the receiver stalls the back end holds, the queue fills and
// s_axis_tready drops. Reset empties the pipeline and queue.
module matrix3_inverse_cramer import mi3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22 (16 bits each)
  input  logic [143:0]           s_axis_tdata,
  // func
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // inv00..inv22 (32 bits each), determinant (49 bits), 7 zero bits
  output logic [343:0]           m_axis_tdata,
  // singular
  output logic                   m_axis_tuser,
  input  logic                   cfg_we,
  input  logic [DET_W-1:0]       cfg_wdata
);

  logic [DET_W-1:0] singular_limit;
  logic [CNT_W-1:0] used;
  logic             accept;
  logic             push, pop, empty, full;
  mi3_job_t         push_data, pop_data;
  logic [N_ENT*INV_W-1:0] inv;
  det_t             det;

  // Hold the limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      singular_limit <= DET_W'(1);
    end else if (cfg_we) begin
      singular_limit <= cfg_wdata;
    end
  end

  // Count beats accepted and not yet popped from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + CNT_W'(accept) - CNT_W'(pop);
    end
  end

  assign s_axis_tready = (used < CNT_W'(FIFO_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;

  mi3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_func   (s_axis_tuser),
    .in_elems  (s_axis_tdata),
    .limit     (singular_limit),
    .push      (push),
    .push_data (push_data)
  );

  mi3_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty),
    .full      (full)
  );

  mi3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_inv   (inv),
    .out_det   (det),
    .out_sing  (m_axis_tuser)
  );

  assign m_axis_tdata = {7'b0, det, inv};

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk) disable iff (rst)
      used <= CNT_W'(FIFO_DEPTH) && !(push && full))
    else $error("credit count out of range");
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && m_axis_tuser |-> inv == '0)
    else $error("singular result with nonzero inverse");
  a_accept_counted: assert property (@(posedge clk) disable iff (rst)
      accept |=> used != '0)
    else $error("accepted beat not counted");
`endif

endmodule
